// ----- sv/u8dec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package u8dec_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] ReplCp = 21'h00FFFD;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;

  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  // work for the back end from one item: replacements first, then an optional tail
  typedef struct packed {
    logic [1:0]     flush_cnt;
    logic           tail_vld;
    logic [CpW-1:0] tail_cp;
    logic           tail_rep;
  } u8dec_job_t;

endpackage

`default_nettype wire

// ----- sv/u8dec_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module u8dec_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [7:0]            text_byte_i,
  input  logic                  end_of_text_i,
  input  logic                  queue_full_i,
  output logic                  in_stall_o,
  output logic                  push_o,
  output u8dec_pkg::u8dec_job_t job_o
);
  import u8dec_pkg::*;

  logic [1:0]     pend_q, pend_d;
  logic [2:0]     len_q, len_d;
  logic [CpW-1:0] gath_q, gath_d;

  logic           accept;
  logic           is_cont;
  logic [1:0]     pend_inc;
  logic [CpW-1:0] gath_next;
  logic           fresh;
  u8dec_job_t     job;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign is_cont    = (text_byte_i & ContMask) == ContCode;
  assign pend_inc   = pend_q + 2'd1;
  assign gath_next  = {gath_q[CpW-7:0], text_byte_i[5:0]};

  always_comb begin
    pend_d = pend_q;
    len_d  = len_q;
    gath_d = gath_q;
    job    = '0;
    fresh  = 1'b1;

    if (end_of_text_i) begin
      job.flush_cnt = pend_q;
      pend_d = '0;
      len_d  = '0;
      gath_d = '0;
      fresh  = 1'b0;
    end else if (pend_q != 2'd0) begin
      if (is_cont) begin
        fresh = 1'b0;
        if (pend_inc == 2'd0 || {1'b0, pend_inc} >= len_q) begin
          job.tail_vld = 1'b1;
          job.tail_cp  = gath_next;
          pend_d = '0;
          len_d  = '0;
          gath_d = '0;
        end else begin
          pend_d = pend_inc;
          gath_d = gath_next;
        end
      end else begin
        // broken sequence: flush held bytes, then decode this byte afresh
        job.flush_cnt = pend_q;
        pend_d = '0;
        len_d  = '0;
        gath_d = '0;
      end
    end

    if (fresh) begin
      priority if (text_byte_i == 8'd0) begin
        job.tail_vld = 1'b0;
      end else if (!text_byte_i[7]) begin
        job.tail_vld = 1'b1;
        job.tail_cp  = CpW'(text_byte_i);
      end else if ((text_byte_i & Lead2Mask) == Lead2Code) begin
        len_d  = SeqLen2;
        pend_d = 2'd1;
        gath_d = CpW'(text_byte_i[4:0]);
      end else if ((text_byte_i & Lead3Mask) == Lead3Code) begin
        len_d  = SeqLen3;
        pend_d = 2'd1;
        gath_d = CpW'(text_byte_i[3:0]);
      end else if ((text_byte_i & Lead4Mask) == Lead4Code) begin
        len_d  = SeqLen4;
        pend_d = 2'd1;
        gath_d = CpW'(text_byte_i[2:0]);
      end else begin
        job.tail_vld = 1'b1;
        job.tail_cp  = ReplCp;
        job.tail_rep = 1'b1;
      end
    end
  end

  assign job_o  = job;
  assign push_o = accept && (job.flush_cnt != 2'd0 || job.tail_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      len_q  <= '0;
      gath_q <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      len_q  <= len_d;
      gath_q <= gath_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/u8dec_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module u8dec_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  u8dec_pkg::u8dec_job_t job_i,
  input  logic                  pop_i,
  output u8dec_pkg::u8dec_job_t head_o,
  output logic                  empty_o,
  output logic                  full_o
);
  import u8dec_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u8dec_job_t      slot_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = cnt_q == CntW'(0);
  assign full_o  = cnt_q == CntW'(Depth);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/u8dec_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module u8dec_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  u8dec_pkg::u8dec_job_t head_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [20:0]           code_point_o,
  output logic                  replaced_o,
  output logic                  last_of_run_o
);
  import u8dec_pkg::*;

  logic [1:0]     cnt_q, cnt_d;
  logic           out_valid_q, out_valid_d;
  logic [CpW-1:0] out_cp_q, out_cp_d;
  logic           out_rep_q, out_rep_d;
  logic           out_last_q, out_last_d;

  logic load, take, is_flush, last_flush;

  assign load       = !out_valid_q || !out_stall_i;
  assign take       = load && !empty_i;
  assign is_flush   = cnt_q < head_i.flush_cnt;
  assign last_flush = ((cnt_q + 2'd1) == head_i.flush_cnt) && !head_i.tail_vld;

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_cp_d    = out_cp_q;
    out_rep_d   = out_rep_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;
    if (take) begin
      out_valid_d = 1'b1;
      if (is_flush) begin
        out_cp_d   = ReplCp;
        out_rep_d  = 1'b1;
        out_last_d = last_flush;
        if (last_flush) begin
          pop_o = 1'b1;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end else begin
        out_cp_d   = head_i.tail_cp;
        out_rep_d  = head_i.tail_rep;
        out_last_d = 1'b1;
        pop_o      = 1'b1;
        cnt_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cp_q   <= out_cp_d;
    out_rep_q  <= out_rep_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = out_cp_q;
  assign replaced_o    = out_rep_q;
  assign last_of_run_o = out_last_q;

  a_cnt_clear_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> cnt_q == 2'd0)
    else $error("flush count not cleared after pop");

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (cnt_q < head_i.flush_cnt || (cnt_q == head_i.flush_cnt && head_i.tail_vld)))
    else $error("flush count past job");

  a_plain_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_rep_q || out_last_q))
    else $error("decoded code point not last of run");

  a_pop_needs_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (take && !empty_i))
    else $error("pop without result");

endmodule

`default_nettype wire

// ----- sv/utf8_stream_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake                payload
// in       input      in_valid_i / in_stall_o   text_byte_i, end_of_text_i
// out      output     out_valid_o / out_stall_i code_point_o, replaced_o, last_of_run_o
//
// one byte is taken per cycle while the job queue has room; decoder state updates on accept
// each byte gives zero to four results, sent one per cycle while out_stall_i is low, from the output register
// the job is queued at the accepting edge; its first result then passes from the queue into the output register
// reset clears decoder state, queue pointers and output valid; no clearing pass
// in_stall_o is raised only when the job queue is full

module utf8_stream_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic        replaced_o,
  output logic        last_of_run_o
);
  import u8dec_pkg::*;

  u8dec_job_t push_job, head_job;
  logic       push, pop, q_empty, q_full;

  u8dec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .queue_full_i (q_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .job_o        (push_job)
  );

  u8dec_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .head_o (head_job),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  u8dec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_point_o (code_point_o),
    .replaced_o   (replaced_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

`default_nettype wire
